// ----- design/assert_macros.svh -----
// Assertion macros for the design files.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Fail when expr is ever true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Fail when cond holds and then exp does not hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, exp, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (exp)) else $error(msg);

`endif

// ----- design/dec_pkg.sv -----
// Types, constants and helpers for the disc contact resolver.
// Used by every module of the block; depends on nothing.
package dec_pkg;

  localparam logic [1:0] ST_NONE       = 2'd0;
  localparam logic [1:0] ST_RESOLVED   = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;

  localparam int DIR_BITS    = 14;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STEPS   = 35;
  localparam int Q_DEPTH     = 4;
  localparam int Q_AW        = $clog2(Q_DEPTH);
  localparam int Q_CW        = $clog2(Q_DEPTH + 1);
  localparam int BACK_DEPTH  = SQRT_STAGES + 2 + DIV_STEPS + 8 + DIV_STEPS + 2 + DIV_STEPS + 1;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic        [15:0] first_mass;
    logic        [30:0] first_rad;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [15:0] second_mass;
    logic        [30:0] second_rad;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_vx;
    logic signed [31:0] new_first_vy;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_vx;
    logic signed [31:0] new_second_vy;
    logic        [1:0]  contact_status;
  } result_t;

  typedef struct packed {
    pair_t       item;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        dxn;
    logic        dyn;
    logic [31:0] rsum;
    logic [63:0] sq;
    logic [1:0]  status;
  } front_t;

  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (v < 40'shFF80000000) begin
      return 32'h80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ----- design/disc_elastic_collision_top.sv -----
// Disc contact resolver. Throughput is one disc pair per cycle unless pair_stall (queue
// full) or res_stall holds the flow, set by the fully pipelined square root (32 stages)
// and the three 35-stage divider banks; a 4-word queue parts front and back.
// Synchronous reset clears valid flags and queue pointers; no clearing pass.
// Top level of the block; depends on dec_pkg, dec_front, dec_queue and dec_back.
module disc_elastic_collision_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  dec_pkg::pair_t   pair,
  output logic             res_valid,
  input  logic             res_stall,
  output dec_pkg::result_t res
);

  logic            push, pop, q_valid, room;
  dec_pkg::front_t front, q_head;

  dec_front u_front (
    .clk(clk), .rst(rst), .pair_valid(pair_valid), .pair_stall(pair_stall),
    .pair(pair), .room(room), .push(push), .front(front)
  );

  dec_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(front), .pop(pop),
    .valid(q_valid), .head(q_head), .room(room)
  );

  dec_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

endmodule

// ----- design/dec_front.sv -----
// Front end: input register, center distance and contact test.
// Depends on dec_pkg; feeds dec_queue.
module dec_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            pair_valid,
  output logic            pair_stall,
  input  dec_pkg::pair_t  pair,
  input  logic            room,
  output logic            push,
  output dec_pkg::front_t front
);

  logic v1, v2, v3, v4;
  dec_pkg::pair_t  s1;
  dec_pkg::front_t s2, s2_next, s3, s4, s4_next;
  logic [63:0] ax2, ay2, rs2;
  logic signed [32:0] dx, dy;
  logic [64:0] sq;

  assign pair_stall = !room;
  assign push       = v4 && room;
  assign front      = s4;

  always_comb begin
    dx = 33'(s1.second_pos_x) - 33'(s1.first_pos_x);
    dy = 33'(s1.second_pos_y) - 33'(s1.first_pos_y);
    s2_next      = '0;
    s2_next.item = s1;
    s2_next.ax   = dx[32] ? 32'(-dx) : dx[31:0];
    s2_next.ay   = dy[32] ? 32'(-dy) : dy[31:0];
    s2_next.dxn  = dx[32];
    s2_next.dyn  = dy[32];
    s2_next.rsum = 32'(s1.first_rad) + 32'(s1.second_rad);
  end

  always_comb begin
    sq = 65'(ax2) + 65'(ay2);
    s4_next    = s3;
    s4_next.sq = sq[63:0];
    if (sq < 65'(rs2)) begin
      s4_next.status = (sq == '0) ? dec_pkg::ST_COINCIDENT : dec_pkg::ST_RESOLVED;
    end else begin
      s4_next.status = dec_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (room) begin
      v1 <= pair_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (room) begin
      s1  <= pair;
      s2  <= s2_next;
      s3  <= s2;
      ax2 <= 64'(s2.ax) * 64'(s2.ax);
      ay2 <= 64'(s2.ay) * 64'(s2.ay);
      rs2 <= 64'(s2.rsum) * 64'(s2.rsum);
      s4  <= s4_next;
    end
  end

endmodule

// ----- design/dec_queue.sv -----
// Short queue between front end and back end.
// Depends on dec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dec_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dec_pkg::front_t din,
  input  logic            pop,
  output logic            valid,
  output dec_pkg::front_t head,
  output logic            room
);

  dec_pkg::front_t mem [0:dec_pkg::Q_DEPTH-1];
  logic [dec_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [dec_pkg::Q_CW-1:0] count;

  assign valid = count != '0;
  assign room  = count != dec_pkg::Q_CW'(dec_pkg::Q_DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && !pop && !room, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && !valid, "queue underflow")
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "count lost a word")

endmodule

// ----- design/dec_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
// Depends on dec_pkg; used by dec_back.
module dec_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [33:0] rem_q  [1:dec_pkg::SQRT_STAGES];
  logic [31:0] root_q [1:dec_pkg::SQRT_STAGES];
  logic [63:0] rad_q  [1:dec_pkg::SQRT_STAGES];

  assign root = root_q[dec_pkg::SQRT_STAGES];

  for (genvar k = 0; k < dec_pkg::SQRT_STAGES; k++) begin : g_step
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] rad_i;
    logic [35:0] r2, trial;
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_rest
      assign rem_i  = rem_q[k];
      assign root_i = root_q[k];
      assign rad_i  = rad_q[k];
    end
    assign r2    = {rem_i, rad_i[63:62]};
    assign trial = {2'b00, root_i, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= trial) begin
          rem_q[k+1]  <= 34'(r2 - trial);
          root_q[k+1] <= {root_i[30:0], 1'b1};
        end else begin
          rem_q[k+1]  <= r2[33:0];
          root_q[k+1] <= {root_i[30:0], 1'b0};
        end
        rad_q[k+1] <= {rad_i[61:0], 2'b00};
      end
    end
  end

endmodule

// ----- design/dec_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dec_pkg; the quotient must fit in 35 bits.
module dec_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [32:0] den,
  output logic [34:0] quo
);

  logic [32:0] r_q [1:dec_pkg::DIV_STEPS];
  logic [34:0] l_q [1:dec_pkg::DIV_STEPS];
  logic [32:0] d_q [1:dec_pkg::DIV_STEPS];

  assign quo = l_q[dec_pkg::DIV_STEPS];

  for (genvar k = 0; k < dec_pkg::DIV_STEPS; k++) begin : g_step
    logic [32:0] r_i, d_i;
    logic [34:0] l_i;
    logic [33:0] r2;
    if (k == 0) begin : g_first
      assign r_i = {4'b0000, num[63:35]};
      assign l_i = num[34:0];
      assign d_i = den;
    end else begin : g_rest
      assign r_i = r_q[k];
      assign l_i = l_q[k];
      assign d_i = d_q[k];
    end
    assign r2 = {r_i, l_i[34]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= {1'b0, d_i}) begin
          r_q[k+1] <= 33'(r2 - {1'b0, d_i});
          l_q[k+1] <= {l_i[33:0], 1'b1};
        end else begin
          r_q[k+1] <= r2[32:0];
          l_q[k+1] <= {l_i[33:0], 1'b0};
        end
        d_q[k+1] <= d_i;
      end
    end
  end

endmodule

// ----- design/dec_back.sv -----
// Back end: separation, direction normalize and velocity exchange pipeline.
// Depends on dec_pkg, dec_sqrt and dec_div; drains dec_queue.
module dec_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dec_pkg::front_t  q_head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output dec_pkg::result_t res
);

  typedef struct packed {
    dec_pkg::pair_t     item;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               dxn;
    logic               dyn;
    logic [31:0]        rsum;
    logic [1:0]         status;
    logic [31:0]        ovl;
    logic [32:0]        dv2;
    logic [63:0]        prx;
    logic [63:0]        pry;
    logic [30:0]        sx;
    logic [30:0]        sy;
    logic [32:0]        nax;
    logic [32:0]        nay;
    logic [4:0]         sh;
    logic signed [14:0] nx;
    logic signed [14:0] ny;
    logic signed [32:0] dvx;
    logic signed [32:0] dvy;
    logic [29:0]        nsqx;
    logic [29:0]        nsqy;
    logic [29:0]        nn;
    logic signed [47:0] px;
    logic signed [47:0] py;
    logic signed [48:0] p;
    logic signed [63:0] pnx;
    logic signed [63:0] pny;
    logic [62:0]        pmx;
    logic [62:0]        pmy;
    logic               psx;
    logic               psy;
    logic [33:0]        qmx;
    logic [33:0]        qmy;
    logic               qsx;
    logic               qsy;
    logic [16:0]        m1x2;
    logic [16:0]        m2x2;
    logic [16:0]        msum;
    logic [50:0]        cax;
    logic [50:0]        cay;
    logic [50:0]        cbx;
    logic [50:0]        cby;
  } work_t;

  logic en;
  logic [dec_pkg::BACK_DEPTH-1:0] vld;
  work_t w0, e1, e1_next, e2, e2_next, g1, g1_next, g2, g2_next, g3, g3_next;
  work_t g4, g4_next, g5, g5_next, g6, g6_next, g7, g7_next, g8, g8_next;
  work_t h1, h1_next, h2, h2_next, wl;
  work_t sl [0:dec_pkg::SQRT_STAGES-1];
  work_t al [0:dec_pkg::DIV_STEPS-1];
  work_t bl [0:dec_pkg::DIV_STEPS-1];
  work_t cl [0:dec_pkg::DIV_STEPS-1];
  logic [31:0] root;
  logic [34:0] qa_x, qa_y, qb_x, qb_y, qc_ax, qc_ay, qc_bx, qc_by;
  logic [32:0] nm;
  logic [5:0]  hi;
  logic [13:0] nxm, nym;
  logic signed [14:0] nxu, nyu;
  logic signed [33:0] sxs, sys;
  logic signed [35:0] cax_s, cay_s, cbx_s, cby_s;
  logic        resolved, vel_ok;
  dec_pkg::result_t res_next;

  assign en        = !(res_valid && res_stall);
  assign pop       = en && q_valid;
  assign res_valid = vld[dec_pkg::BACK_DEPTH-1];

  always_comb begin
    w0        = '0;
    w0.item   = q_head.item;
    w0.ax     = q_head.ax;
    w0.ay     = q_head.ay;
    w0.dxn    = q_head.dxn;
    w0.dyn    = q_head.dyn;
    w0.rsum   = q_head.rsum;
    w0.status = q_head.status;
  end

  dec_sqrt u_sqrt (.clk(clk), .en(en), .rad(q_head.sq), .root(root));

  always_comb begin
    e1_next     = sl[dec_pkg::SQRT_STAGES-1];
    e1_next.ovl = sl[dec_pkg::SQRT_STAGES-1].rsum - root;
    e1_next.dv2 = {root, 1'b0};
    e2_next     = e1;
    e2_next.prx = 64'(e1.ovl) * 64'(e1.ax);
    e2_next.pry = 64'(e1.ovl) * 64'(e1.ay);
  end

  dec_div u_div_ax (.clk(clk), .en(en), .num(e2.prx), .den(e2.dv2), .quo(qa_x));
  dec_div u_div_ay (.clk(clk), .en(en), .num(e2.pry), .den(e2.dv2), .quo(qa_y));

  always_comb begin
    g1_next     = al[dec_pkg::DIV_STEPS-1];
    g1_next.sx  = qa_x[30:0];
    g1_next.sy  = qa_y[30:0];
    g1_next.nax = 33'(al[dec_pkg::DIV_STEPS-1].ax) + 33'({qa_x[30:0], 1'b0});
    g1_next.nay = 33'(al[dec_pkg::DIV_STEPS-1].ay) + 33'({qa_y[30:0], 1'b0});
  end

  always_comb begin
    nm = g1.nax | g1.nay;
    hi = '0;
    for (int i = 0; i < 33; i++) begin
      if (nm[i]) begin
        hi = 6'(i);
      end
    end
    g2_next    = g1;
    g2_next.sh = (hi >= 6'(dec_pkg::DIR_BITS)) ? 5'(hi - 6'(dec_pkg::DIR_BITS - 1)) : '0;
  end

  always_comb begin
    nxm        = 14'(g2.nax >> g2.sh);
    nym        = 14'(g2.nay >> g2.sh);
    nxu        = $signed({1'b0, nxm});
    nyu        = $signed({1'b0, nym});
    g3_next    = g2;
    g3_next.nx = g2.dxn ? -nxu : nxu;
    g3_next.ny = g2.dyn ? -nyu : nyu;
  end

  always_comb begin
    g4_next      = g3;
    g4_next.dvx  = 33'(g3.item.second_vel_x) - 33'(g3.item.first_vel_x);
    g4_next.dvy  = 33'(g3.item.second_vel_y) - 33'(g3.item.first_vel_y);
    g4_next.nsqx = 30'(g3.nx) * 30'(g3.nx);
    g4_next.nsqy = 30'(g3.ny) * 30'(g3.ny);
    g5_next      = g4;
    g5_next.px   = 48'(g4.dvx) * 48'(g4.nx);
    g5_next.py   = 48'(g4.dvy) * 48'(g4.ny);
    g5_next.nn   = g4.nsqx + g4.nsqy;
    g6_next      = g5;
    g6_next.p    = 49'(g5.px) + 49'(g5.py);
    g7_next      = g6;
    g7_next.pnx  = 64'(g6.p) * 64'(g6.nx);
    g7_next.pny  = 64'(g6.p) * 64'(g6.ny);
    g8_next      = g7;
    g8_next.psx  = g7.pnx[63];
    g8_next.psy  = g7.pny[63];
    g8_next.pmx  = g7.pnx[63] ? 63'(-g7.pnx) : g7.pnx[62:0];
    g8_next.pmy  = g7.pny[63] ? 63'(-g7.pny) : g7.pny[62:0];
  end

  dec_div u_div_bx (.clk(clk), .en(en), .num({1'b0, g8.pmx}), .den({3'b000, g8.nn}),
                    .quo(qb_x));
  dec_div u_div_by (.clk(clk), .en(en), .num({1'b0, g8.pmy}), .den({3'b000, g8.nn}),
                    .quo(qb_y));

  always_comb begin
    h1_next      = bl[dec_pkg::DIV_STEPS-1];
    h1_next.qmx  = qb_x[33:0];
    h1_next.qmy  = qb_y[33:0];
    h1_next.qsx  = bl[dec_pkg::DIV_STEPS-1].psx;
    h1_next.qsy  = bl[dec_pkg::DIV_STEPS-1].psy;
    h1_next.m1x2 = {bl[dec_pkg::DIV_STEPS-1].item.first_mass, 1'b0};
    h1_next.m2x2 = {bl[dec_pkg::DIV_STEPS-1].item.second_mass, 1'b0};
    h1_next.msum = 17'(bl[dec_pkg::DIV_STEPS-1].item.first_mass)
                 + 17'(bl[dec_pkg::DIV_STEPS-1].item.second_mass);
    h2_next      = h1;
    h2_next.cax  = 51'(h1.qmx) * 51'(h1.m2x2);
    h2_next.cay  = 51'(h1.qmy) * 51'(h1.m2x2);
    h2_next.cbx  = 51'(h1.qmx) * 51'(h1.m1x2);
    h2_next.cby  = 51'(h1.qmy) * 51'(h1.m1x2);
  end

  dec_div u_div_cax (.clk(clk), .en(en), .num(64'(h2.cax)), .den(33'(h2.msum)), .quo(qc_ax));
  dec_div u_div_cay (.clk(clk), .en(en), .num(64'(h2.cay)), .den(33'(h2.msum)), .quo(qc_ay));
  dec_div u_div_cbx (.clk(clk), .en(en), .num(64'(h2.cbx)), .den(33'(h2.msum)), .quo(qc_bx));
  dec_div u_div_cby (.clk(clk), .en(en), .num(64'(h2.cby)), .den(33'(h2.msum)), .quo(qc_by));

  always_comb begin
    wl       = cl[dec_pkg::DIV_STEPS-1];
    resolved = wl.status == dec_pkg::ST_RESOLVED;
    vel_ok   = resolved && (wl.nn != '0) && (wl.msum != '0);
    sxs      = wl.dxn ? -$signed(34'(wl.sx)) : $signed(34'(wl.sx));
    sys      = wl.dyn ? -$signed(34'(wl.sy)) : $signed(34'(wl.sy));
    cax_s    = wl.qsx ? -$signed(36'(qc_ax)) : $signed(36'(qc_ax));
    cay_s    = wl.qsy ? -$signed(36'(qc_ay)) : $signed(36'(qc_ay));
    cbx_s    = wl.qsx ? -$signed(36'(qc_bx)) : $signed(36'(qc_bx));
    cby_s    = wl.qsy ? -$signed(36'(qc_by)) : $signed(36'(qc_by));
    res_next.contact_status = wl.status;
    if (resolved) begin
      res_next.new_first_x  = dec_pkg::sat32(40'(wl.item.first_pos_x) - 40'(sxs));
      res_next.new_first_y  = dec_pkg::sat32(40'(wl.item.first_pos_y) - 40'(sys));
      res_next.new_second_x = dec_pkg::sat32(40'(wl.item.second_pos_x) + 40'(sxs));
      res_next.new_second_y = dec_pkg::sat32(40'(wl.item.second_pos_y) + 40'(sys));
    end else begin
      res_next.new_first_x  = wl.item.first_pos_x;
      res_next.new_first_y  = wl.item.first_pos_y;
      res_next.new_second_x = wl.item.second_pos_x;
      res_next.new_second_y = wl.item.second_pos_y;
    end
    if (vel_ok) begin
      res_next.new_first_vx  = dec_pkg::sat32(40'(wl.item.first_vel_x) + 40'(cax_s));
      res_next.new_first_vy  = dec_pkg::sat32(40'(wl.item.first_vel_y) + 40'(cay_s));
      res_next.new_second_vx = dec_pkg::sat32(40'(wl.item.second_vel_x) - 40'(cbx_s));
      res_next.new_second_vy = dec_pkg::sat32(40'(wl.item.second_vel_y) - 40'(cby_s));
    end else begin
      res_next.new_first_vx  = wl.item.first_vel_x;
      res_next.new_first_vy  = wl.item.first_vel_y;
      res_next.new_second_vx = wl.item.second_vel_x;
      res_next.new_second_vy = wl.item.second_vel_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[dec_pkg::BACK_DEPTH-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl[0] <= w0;
      for (int k = 1; k < dec_pkg::SQRT_STAGES; k++) begin
        sl[k] <= sl[k-1];
      end
      e1    <= e1_next;
      e2    <= e2_next;
      al[0] <= e2;
      bl[0] <= g8;
      cl[0] <= h2;
      for (int k = 1; k < dec_pkg::DIV_STEPS; k++) begin
        al[k] <= al[k-1];
        bl[k] <= bl[k-1];
        cl[k] <= cl[k-1];
      end
      g1  <= g1_next;
      g2  <= g2_next;
      g3  <= g3_next;
      g4  <= g4_next;
      g5  <= g5_next;
      g6  <= g6_next;
      g7  <= g7_next;
      g8  <= g8_next;
      h1  <= h1_next;
      h2  <= h2_next;
      res <= res_next;
    end
  end

endmodule
